/* hw/rtl/hcc_pkg.sv */
// ----------------------------------------------------------------------------
// hcc_pkg
// Types, constants and the quarter-wave sine table for the hysteresis
// current controller.
// ----------------------------------------------------------------------------
package hcc_pkg;

  localparam int CURRENT_WIDTH    = 16;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SINE_IDXP_W      = 30 + SINE_IDX_W;

  localparam int ADC_W    = 12;
  localparam int AMPS_W   = 16;
  localparam int LEVEL_W  = 16;
  localparam int BAND_W   = 15;
  localparam int COUNT_W  = 20;
  localparam int PHASE_W  = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam int PROD_W = ADC_W + 1 + AMPS_W + 1;
  localparam int SAT_W  = 34;
  localparam int CMP_W  = ((CURRENT_WIDTH > LEVEL_W) ? CURRENT_WIDTH : LEVEL_W) + 3;

  localparam logic signed [SAT_W-1:0] CUR_MAX =
    SAT_W'((64'sd1 <<< (CURRENT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] CUR_MIN = -CUR_MAX - SAT_W'(1);

  localparam logic [16:0] HALF_SCALE = 17'd32768;

  localparam int MQ_DEPTH  = 4;
  localparam int MQ_PTR_W  = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W  = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH  = 8;
  localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ADC_OFFSET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPS_PER_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_LOW_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_HIGH_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE      = 3'd7;

  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_SINE   = 2'd2,
    MODE_CONST  = 2'd3
  } wave_mode_t;

  typedef struct packed {
    logic [ADC_W-1:0]          adc_offset;
    logic [AMPS_W-1:0]         amps_per_code;
    logic signed [LEVEL_W-1:0] ref_low_level;
    logic signed [LEVEL_W-1:0] ref_high_level;
    logic [BAND_W-1:0]         band_width;
    logic [COUNT_W-1:0]        period_ticks;
    logic [PHASE_W-1:0]        phase_step;
    wave_mode_t                wave_mode;
  } cfg_t;

  typedef struct packed {
    logic                      low_side_on;
    logic                      high_side_on;
    logic signed [LEVEL_W-1:0] measured_current;
    logic signed [LEVEL_W-1:0] reference_current;
  } result_t;

  typedef logic [15:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Q15 quarter sine, fixed-point Taylor series in Q30
  function automatic sine_tab_t build_sine_table();
    sine_tab_t tab;
    longint unsigned u;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned v;
    for (int q = 0; q <= SINE_TABLE_DEPTH; q++) begin
      u  = (longint'(q) << 30) / SINE_TABLE_DEPTH;
      x  = (u * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
      v  = (((x * t) >> 30) + 64'd16384) >> 15;
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      tab[q] = v[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

/* hw/rtl/hcc_front.sv */
// ----------------------------------------------------------------------------
// hcc_front
// Takes ADC beats, removes the offset and scales to a saturated current.
// ----------------------------------------------------------------------------
module hcc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [11:0]                 adc_code,
  input  hcc_pkg::cfg_t               cfg,
  input  logic [hcc_pkg::MQ_CNT_W-1:0] mq_level,
  output logic                        mq_write,
  output logic signed [hcc_pkg::CURRENT_WIDTH-1:0] mq_data
);
  import hcc_pkg::*;

  logic                     f1_valid;
  logic signed [PROD_W-1:0] f1_prod;
  logic                     accept;
  logic signed [ADC_W:0]    diff;
  logic signed [AMPS_W:0]   amps_s;
  logic signed [SAT_W-1:0]  shifted;
  logic signed [SAT_W-1:0]  sat;

  // credit: queue entries plus the beat being scaled
  assign full = ((MQ_CNT_W + 1)'(mq_level) + (MQ_CNT_W + 1)'(f1_valid))
                >= (MQ_CNT_W + 1)'(MQ_DEPTH);
  assign accept = push && !full;

  assign diff   = signed'({1'b0, adc_code}) - signed'({1'b0, cfg.adc_offset});
  assign amps_s = signed'({1'b0, cfg.amps_per_code});

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
    if (accept) begin
      f1_prod <= diff * amps_s;
    end
  end

  always_comb begin
    shifted = SAT_W'(f1_prod) >>> 10;
    if (shifted > CUR_MAX) begin
      sat = CUR_MAX;
    end else if (shifted < CUR_MIN) begin
      sat = CUR_MIN;
    end else begin
      sat = shifted;
    end
  end

  assign mq_write = f1_valid;
  assign mq_data  = sat[CURRENT_WIDTH-1:0];

endmodule

/* hw/rtl/hcc_mid_queue.sv */
// ----------------------------------------------------------------------------
// hcc_mid_queue
// Short queue of scaled currents between the front and back parts.
// ----------------------------------------------------------------------------
module hcc_mid_queue (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     write,
  input  logic signed [hcc_pkg::CURRENT_WIDTH-1:0] wdata,
  input  logic                                     read,
  output logic signed [hcc_pkg::CURRENT_WIDTH-1:0] rdata,
  output logic [hcc_pkg::MQ_CNT_W-1:0]             level
);
  import hcc_pkg::*;

  logic signed [CURRENT_WIDTH-1:0] mem [MQ_DEPTH];
  logic [MQ_PTR_W-1:0]             wr_ptr;
  logic [MQ_PTR_W-1:0]             rd_ptr;

  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (write) begin
        wr_ptr <= (wr_ptr == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (read) begin
        rd_ptr <= (rd_ptr == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({write, read})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
    if (write) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* hw/rtl/hcc_result_queue.sv */
// ----------------------------------------------------------------------------
// hcc_result_queue
// Output queue of result beats.
// ----------------------------------------------------------------------------
module hcc_result_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write,
  input  hcc_pkg::result_t             wdata,
  input  logic                         pop,
  output logic                         empty,
  output hcc_pkg::result_t             head,
  output logic [hcc_pkg::OQ_CNT_W-1:0] level
);
  import hcc_pkg::*;

  result_t             mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic                read;

  assign empty = (level == '0);
  assign read  = pop && !empty;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (write) begin
        wr_ptr <= (wr_ptr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (read) begin
        rd_ptr <= (rd_ptr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({write, read})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
    if (write) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* hw/rtl/hcc_back.sv */
// ----------------------------------------------------------------------------
// hcc_back
// Reference generation (square, sine, hold, constant) and hysteresis
// comparison; writes result beats to the output queue.
// ----------------------------------------------------------------------------
module hcc_back (
  input  logic                                     clk,
  input  logic                                     rst,
  input  hcc_pkg::cfg_t                            cfg,
  input  logic [hcc_pkg::MQ_CNT_W-1:0]             mq_level,
  input  logic signed [hcc_pkg::CURRENT_WIDTH-1:0] mq_data,
  output logic                                     mq_read,
  input  logic [hcc_pkg::OQ_CNT_W-1:0]             oq_level,
  output logic                                     res_write,
  output hcc_pkg::result_t                         res_data
);
  import hcc_pkg::*;

  logic [COUNT_W-1:0]        sample_count;
  logic [PHASE_W-1:0]        phase_accumulator;
  logic signed [LEVEL_W-1:0] reference_level;
  logic                      low_side_state;
  logic                      high_side_state;

  // stage 1: reference step, table index
  logic                            b1_valid;
  logic signed [CURRENT_WIDTH-1:0] b1_cur;
  logic                            b1_sine;
  logic signed [LEVEL_W-1:0]       b1_ref;
  logic [SINE_IDX_W-1:0]           b1_tidx;
  logic                            b1_neg;
  // stage 2: table read
  logic                            b2_valid;
  logic signed [CURRENT_WIDTH-1:0] b2_cur;
  logic                            b2_sine;
  logic signed [LEVEL_W-1:0]       b2_ref;
  logic [16:0]                     b2_frac;
  logic signed [LEVEL_W:0]         b2_diff;
  // stage 3: product
  logic                            b3_valid;
  logic signed [CURRENT_WIDTH-1:0] b3_cur;
  logic                            b3_sine;
  logic signed [LEVEL_W-1:0]       b3_ref;
  logic signed [34:0]              b3_prod;

  logic [OQ_CNT_W:0]         inflight;
  logic [COUNT_W-1:0]        cnt_inc;
  logic [COUNT_W-1:0]        count_next;
  logic [PHASE_W-1:0]        phase_sum;
  logic                      sine_active;
  logic signed [LEVEL_W-1:0] ref_pre;
  logic [SINE_IDXP_W-1:0]    idx_prod;
  logic [SINE_IDX_W-1:0]     idx;
  logic [SINE_IDX_W-1:0]     tidx;
  logic [15:0]               mag;
  logic signed [LEVEL_W-1:0] sine_ref;
  logic signed [LEVEL_W-1:0] ref_fin;
  logic signed [CMP_W-1:0]   cur2;
  logic signed [CMP_W-1:0]   ref2;
  logic signed [CMP_W-1:0]   band_x;
  logic                      below;
  logic                      above;
  logic                      low_next;
  logic                      high_next;

  assign inflight = (OQ_CNT_W + 1)'(b1_valid) + (OQ_CNT_W + 1)'(b2_valid)
                  + (OQ_CNT_W + 1)'(b3_valid);
  assign mq_read  = (mq_level != '0)
                 && ((inflight + (OQ_CNT_W + 1)'(oq_level)) < (OQ_CNT_W + 1)'(OQ_DEPTH));

  always_comb begin
    cnt_inc     = sample_count + 1'b1;
    count_next  = cnt_inc;
    phase_sum   = phase_accumulator + cfg.phase_step;
    sine_active = 1'b0;
    ref_pre     = reference_level;
    case (cfg.wave_mode)
      MODE_SQUARE: begin
        if (cnt_inc >= cfg.period_ticks) begin
          count_next = '0;
          ref_pre    = (reference_level == cfg.ref_low_level) ?
                       cfg.ref_high_level : cfg.ref_low_level;
        end
      end
      MODE_SINE: begin
        if (cfg.phase_step == '0) begin
          ref_pre = cfg.ref_high_level;
        end else begin
          sine_active = 1'b1;
        end
      end
      MODE_CONST: begin
        ref_pre = cfg.ref_high_level;
      end
      default: begin
        ref_pre = reference_level;
      end
    endcase
    idx_prod = SINE_IDXP_W'(phase_sum[29:0]) * SINE_IDXP_W'(SINE_TABLE_DEPTH);
    idx      = idx_prod[30 +: SINE_IDX_W];
    tidx     = phase_sum[30] ? SINE_IDX_W'(SINE_TABLE_DEPTH) - idx : idx;
  end

  assign mag = SINE_TABLE[b1_tidx];

  always_comb begin
    sine_ref  = cfg.ref_low_level + b3_prod[31:16];
    ref_fin   = b3_sine ? sine_ref : b3_ref;
    cur2      = CMP_W'(b3_cur) <<< 1;
    ref2      = CMP_W'(ref_fin) <<< 1;
    band_x    = signed'(CMP_W'(cfg.band_width));
    below     = cur2 < (ref2 - band_x);
    above     = cur2 > (ref2 + band_x);
    low_next  = below ? 1'b1 : (above ? 1'b0 : low_side_state);
    high_next = (below || above) ? 1'b1 : high_side_state;
  end

  assign res_write                  = b3_valid;
  assign res_data.low_side_on       = low_next;
  assign res_data.high_side_on      = high_next;
  assign res_data.measured_current  = LEVEL_W'(b3_cur);
  assign res_data.reference_current = ref_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count      <= '0;
      phase_accumulator <= '0;
      reference_level   <= '0;
      low_side_state    <= 1'b0;
      high_side_state   <= 1'b0;
      b1_valid          <= 1'b0;
      b2_valid          <= 1'b0;
      b3_valid          <= 1'b0;
    end else begin
      b1_valid <= mq_read;
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
      if (mq_read) begin
        sample_count <= count_next;
        if (sine_active) begin
          phase_accumulator <= phase_sum;
        end
      end
      if (b3_valid && b3_sine) begin
        reference_level <= sine_ref;
      end else if (mq_read && !sine_active) begin
        reference_level <= ref_pre;
      end
      if (b3_valid) begin
        low_side_state  <= low_next;
        high_side_state <= high_next;
      end
    end
    b1_cur  <= mq_data;
    b1_sine <= sine_active;
    b1_ref  <= ref_pre;
    b1_tidx <= tidx;
    b1_neg  <= phase_sum[31];
    b2_cur  <= b1_cur;
    b2_sine <= b1_sine;
    b2_ref  <= b1_ref;
    b2_frac <= b1_neg ? HALF_SCALE - {1'b0, mag} : HALF_SCALE + {1'b0, mag};
    b2_diff <= (LEVEL_W + 1)'(cfg.ref_high_level) - (LEVEL_W + 1)'(cfg.ref_low_level);
    b3_cur  <= b2_cur;
    b3_sine <= b2_sine;
    b3_ref  <= b2_ref;
    b3_prod <= b2_diff * signed'({1'b0, b2_frac});
  end

endmodule

/* hw/rtl/hysteresis_current_controller_core.sv */
// ----------------------------------------------------------------------------
// hysteresis_current_controller_core
// Hysteresis current controller: ADC scaling, reference waveform and
// two-switch gate decision, one beat per ADC sample.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  input     push / full         adc_code
//  result    empty / pop         low_side_on, high_side_on,
//                                measured_current, reference_current
//  config    cfg_write           cfg_index, cfg_data
//
//  Sustains one beat per cycle when nothing stalls; a result passes the scale
//  register, the mid queue, three reference stages and the result queue write
//  before it is on the ports.
//  Reset is synchronous: registers to defaults, waveform and gate state zero.
//  full rises when the mid queue would overflow; the back part stops pulling
//  from it when the result queue has no room for the beats in flight.
// ----------------------------------------------------------------------------
module hysteresis_current_controller_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [11:0]                        adc_code,
  output logic                               empty,
  input  logic                               pop,
  output logic                               low_side_on,
  output logic                               high_side_on,
  output logic signed [15:0]                 measured_current,
  output logic signed [15:0]                 reference_current,
  input  logic                               cfg_write,
  input  logic [hcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hcc_pkg::CFG_W-1:0]          cfg_data
);
  import hcc_pkg::*;

  cfg_t                            cfg;
  logic                            mq_write;
  logic signed [CURRENT_WIDTH-1:0] mq_wdata;
  logic signed [CURRENT_WIDTH-1:0] mq_rdata;
  logic                            mq_read;
  logic [MQ_CNT_W-1:0]             mq_level;
  logic                            res_write;
  result_t                         res_data;
  result_t                         head;
  logic [OQ_CNT_W-1:0]             oq_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_offset     <= 12'd470;
      cfg.amps_per_code  <= 16'd3840;
      cfg.ref_low_level  <= 16'sd0;
      cfg.ref_high_level <= 16'sd1024;
      cfg.band_width     <= 15'd205;
      cfg.period_ticks   <= 20'd50000;
      cfg.phase_step     <= 32'd85899;
      cfg.wave_mode      <= MODE_SINE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ADC_OFFSET:     cfg.adc_offset     <= cfg_data[ADC_W-1:0];
        REG_AMPS_PER_CODE:  cfg.amps_per_code  <= cfg_data[AMPS_W-1:0];
        REG_REF_LOW_LEVEL:  cfg.ref_low_level  <= cfg_data[LEVEL_W-1:0];
        REG_REF_HIGH_LEVEL: cfg.ref_high_level <= cfg_data[LEVEL_W-1:0];
        REG_BAND_WIDTH:     cfg.band_width     <= cfg_data[BAND_W-1:0];
        REG_PERIOD_TICKS:   cfg.period_ticks   <= cfg_data[COUNT_W-1:0];
        REG_PHASE_STEP:     cfg.phase_step     <= cfg_data[PHASE_W-1:0];
        REG_WAVE_MODE:      cfg.wave_mode      <= wave_mode_t'(cfg_data[1:0]);
        default: begin
        end
      endcase
    end
  end

  hcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .adc_code (adc_code),
    .cfg      (cfg),
    .mq_level (mq_level),
    .mq_write (mq_write),
    .mq_data  (mq_wdata)
  );

  hcc_mid_queue u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .write (mq_write),
    .wdata (mq_wdata),
    .read  (mq_read),
    .rdata (mq_rdata),
    .level (mq_level)
  );

  hcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mq_level  (mq_level),
    .mq_data   (mq_rdata),
    .mq_read   (mq_read),
    .oq_level  (oq_level),
    .res_write (res_write),
    .res_data  (res_data)
  );

  hcc_result_queue u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .write (res_write),
    .wdata (res_data),
    .pop   (pop),
    .empty (empty),
    .head  (head),
    .level (oq_level)
  );

  assign low_side_on       = head.low_side_on;
  assign high_side_on      = head.high_side_on;
  assign measured_current  = head.measured_current;
  assign reference_current = head.reference_current;

endmodule
